// ===== rtl/core/tcw_pkg.sv =====
package tcw_pkg;

  // Field widths of the stream payloads and the configuration register.
  localparam int CMD_W      = 2;
  localparam int CHAR_W     = 8;
  localparam int NCOL_W     = 7;
  localparam int NROW_W     = 5;
  localparam int RIDX_W     = 11;
  localparam int OCOL_W     = 7;
  localparam int OROW_W     = 5;
  localparam int OIDX_W     = 11;
  localparam int CELL_W     = 16;
  localparam int ATTR_W     = 8;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

  typedef enum logic [CMD_W-1:0] {
    CMD_PRINT = 2'd0,
    CMD_SET   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  // Status of the screen sweep unit for the current cycle.
  typedef struct packed {
    logic done;
    logic wr_en;
    logic rd_en;
    logic copy;
  } sweep_stat_t;

endpackage

// ===== rtl/core/tcw_ram.sv =====
module tcw_ram import tcw_pkg::*; #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/core/tcw_sweep.sv =====
module tcw_sweep import tcw_pkg::*; #(
  parameter int unsigned COLS = 80,
  parameter int unsigned ROWS = 25
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output sweep_stat_t                   stat_o,
  output logic [$clog2(COLS*ROWS)-1:0]  waddr_o,
  output logic [$clog2(COLS*ROWS)-1:0]  raddr_o
);

  localparam int unsigned CELLS  = COLS * ROWS;
  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam int unsigned CNT_W  = $clog2(CELLS + 1);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;

  // The counter walks 0..CELLS. At step n it reads cell n+COLS and writes
  // cell n-1, so every cell is written once, in the cycle after its source read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == CNT_W'(CELLS)) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  assign stat_o.done  = busy_q && (cnt_q == CNT_W'(CELLS));
  assign stat_o.wr_en = busy_q && (cnt_q != '0);
  assign stat_o.rd_en = busy_q && (cnt_q < CNT_W'(CELLS - COLS));
  assign stat_o.copy  = cnt_q < CNT_W'(CELLS - COLS + 1);
  assign waddr_o      = ADDR_W'(cnt_q - CNT_W'(1));
  assign raddr_o      = ADDR_W'(cnt_q + CNT_W'(COLS));

endmodule

// ===== rtl/core/text_console_writer.sv =====
// Channel        Direction  Handshake                    Payload
// s_axis         in         s_axis_tvalid/s_axis_tready  tuser: cmd; tdata: char, cursor, index
// m_axis         out        m_axis_tvalid/m_axis_tready  tdata: cursor, index, cell, scroll flag
// cfg            in         cfg_we_i (no wait)           cfg_wdata_i: attribute byte
//
// A print that does not scroll, a cursor set and a no-op complete from the ready
// state directly. A cell read goes through the registered read port of the screen
// memory and a read state. A print that leaves the last row goes to the scroll
// state: the sweep unit moves the screen up one cell per cycle through the single
// memory write port. After reset the same unit clears the screen before the first
// transfer is taken. The result waits in an output register; a new command is taken
// in the cycle that register is emptied.
module text_console_writer import tcw_pkg::*; #(
  parameter int unsigned COLS     = 80,
  parameter int unsigned ROWS     = 25,
  parameter int unsigned TAB_STEP = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [7:0] char_code, [14:8] new_col, [19:15] new_row, [30:20] read_index
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] cmd
  input  logic [CMD_W-1:0]      s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [6:0] cursor_col, [11:7] cursor_row, [22:12] cursor_index,
  // [38:23] cell_value, [39] did_scroll
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_we_i,
  input  logic [ATTR_W-1:0]     cfg_wdata_i
);

  localparam int unsigned CELLS  = COLS * ROWS;
  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam int unsigned CNT_W  = $clog2(CELLS + 1);
  localparam int unsigned CQ_W   = $clog2(COLS);
  localparam int unsigned CS_W   = $clog2(COLS + TAB_STEP);
  localparam int unsigned ROW_W  = $clog2(ROWS);
  localparam int unsigned CMP_W  = CNT_W + RIDX_W;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SCROLL
  } state_e;

  typedef struct packed {
    logic              did_scroll;
    logic [CELL_W-1:0] cell_value;
    logic [OIDX_W-1:0] cursor_index;
    logic [OROW_W-1:0] cursor_row;
    logic [OCOL_W-1:0] cursor_col;
  } out_beat_t;

  // Next tab stop: the smallest multiple of the tab step above the column.
  // Every multiple is compared with the column side by side, and only the
  // one just above the column passes.
  function automatic logic [CS_W-1:0] next_tab_stop(input logic [CQ_W-1:0] v);
    logic [CS_W-1:0] stop;
    stop = '0;
    for (int k = 1; k <= (COLS - 1) / TAB_STEP + 1; k++) begin
      if ((CS_W'(k * TAB_STEP) > CS_W'(v)) &&
          (CS_W'((k - 1) * TAB_STEP) <= CS_W'(v))) begin
        stop = stop | CS_W'(k * TAB_STEP);
      end
    end
    return stop;
  endfunction

  state_e            state_q;
  logic [CQ_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [ATTR_W-1:0] attr_q;
  logic              out_valid_q;
  out_beat_t         out_q;
  out_beat_t         beat;
  logic              rd_ok_q;

  logic              acc;
  cmd_e              cmd;
  logic [CHAR_W-1:0] char_code;
  logic [NCOL_W-1:0] new_col;
  logic [NROW_W-1:0] new_row;
  logic [RIDX_W-1:0] read_index;
  logic              read_in_range;

  logic [CS_W-1:0]   tab_stop;
  logic [CS_W-1:0]   col_inc;
  logic              line_feed;
  logic              scroll;
  logic              wr_char;
  logic [ADDR_W-1:0] pos_q_lin;
  logic [ADDR_W-1:0] pos_d_lin;

  sweep_stat_t       sw_stat;
  logic [ADDR_W-1:0] sw_waddr;
  logic [ADDR_W-1:0] sw_raddr;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  // A command is taken only in the ready state and only when the output
  // register is free or is being emptied in the same cycle.
  assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign acc           = s_axis_tvalid && s_axis_tready;

  assign cmd        = cmd_e'(s_axis_tuser);
  assign char_code  = s_axis_tdata[7:0];
  assign new_col    = s_axis_tdata[14:8];
  assign new_row    = s_axis_tdata[19:15];
  assign read_index = s_axis_tdata[30:20];

  assign read_in_range = CMP_W'(read_index) < CMP_W'(CELLS);

  assign tab_stop  = next_tab_stop(col_q);
  assign col_inc   = CS_W'(col_q) + CS_W'(1);
  assign pos_q_lin = ADDR_W'(row_q) * ADDR_W'(COLS) + ADDR_W'(col_q);
  assign pos_d_lin = ADDR_W'(row_d) * ADDR_W'(COLS) + ADDR_W'(col_d);

  // Next cursor position. A line feed goes to column zero of the next row;
  // on the last row it keeps the row and starts a scroll instead.
  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    line_feed = 1'b0;
    scroll    = 1'b0;
    wr_char   = 1'b0;
    if (acc) begin
      unique case (cmd)
        CMD_PRINT: begin
          if (char_code == CH_NEWLINE) begin
            line_feed = 1'b1;
          end else if (char_code == CH_TAB) begin
            if (tab_stop >= CS_W'(COLS)) begin
              line_feed = 1'b1;
            end else begin
              col_d = CQ_W'(tab_stop);
            end
          end else begin
            wr_char = 1'b1;
            if (col_inc >= CS_W'(COLS)) begin
              line_feed = 1'b1;
            end else begin
              col_d = CQ_W'(col_inc);
            end
          end
        end
        CMD_SET: begin
          col_d = (CMP_W'(new_col) < CMP_W'(COLS)) ? CQ_W'(new_col) : CQ_W'(COLS - 1);
          row_d = (CMP_W'(new_row) < CMP_W'(ROWS)) ? ROW_W'(new_row) : ROW_W'(ROWS - 1);
        end
        CMD_READ, CMD_NOP: begin
        end
      endcase
      if (line_feed) begin
        col_d = '0;
        if (row_q == ROW_W'(ROWS - 1)) begin
          scroll = 1'b1;
        end else begin
          row_d = row_q + ROW_W'(1);
        end
      end
    end
  end

  // The result beat always reports the cursor after the command; the cell
  // and the scroll flag are filled in by the state that completes it.
  always_comb begin
    beat.cursor_col   = OCOL_W'(col_d);
    beat.cursor_row   = OROW_W'(row_d);
    beat.cursor_index = OIDX_W'(pos_d_lin);
    beat.cell_value   = '0;
    beat.did_scroll   = 1'b0;
    unique case (state_q)
      ST_READ:   beat.cell_value = rd_ok_q ? ram_rdata : '0;
      ST_SCROLL: beat.did_scroll = 1'b1;
      ST_INIT, ST_IDLE: begin
      end
    endcase
  end

  // Screen memory ports: the command path owns them in the ready state, the
  // sweep unit during the clearing pass and a scroll. The clearing pass
  // writes zeros; a scroll copies each row up and blanks the bottom row.
  always_comb begin
    if (state_q == ST_IDLE) begin
      ram_we    = wr_char;
      ram_waddr = pos_q_lin;
      ram_wdata = {attr_q, char_code};
      ram_re    = acc && (cmd == CMD_READ) && read_in_range;
      ram_raddr = ADDR_W'(read_index);
    end else begin
      ram_we    = sw_stat.wr_en;
      ram_waddr = sw_waddr;
      if (state_q == ST_INIT) begin
        ram_wdata = '0;
      end else if (sw_stat.copy) begin
        ram_wdata = ram_rdata;
      end else begin
        ram_wdata = {attr_q, CH_SPACE};
      end
      ram_re    = sw_stat.rd_en;
      ram_raddr = sw_raddr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      col_q       <= '0;
      row_q       <= '0;
      attr_q      <= ATTR_RESET;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      rd_ok_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        attr_q <= cfg_wdata_i;
      end
      if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_INIT: begin
          if (sw_stat.done) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (acc) begin
            col_q <= col_d;
            row_q <= row_d;
            if (cmd == CMD_READ) begin
              rd_ok_q <= read_in_range;
              state_q <= ST_READ;
            end else if (scroll) begin
              state_q <= ST_SCROLL;
            end else begin
              out_q       <= beat;
              out_valid_q <= 1'b1;
            end
          end
        end
        ST_READ: begin
          out_q       <= beat;
          out_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        ST_SCROLL: begin
          if (sw_stat.done) begin
            out_q       <= beat;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  tcw_sweep #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_sweep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (acc && scroll),
    .stat_o  (sw_stat),
    .waddr_o (sw_waddr),
    .raddr_o (sw_raddr)
  );

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule
